FILE: design/yjed_pkg.sv
// shared types, constants and helpers for the escape sequence decoder
package yjed_pkg;

   // window geometry
   localparam logic [3:0] WINDOW_BYTES = 4'd12;
   localparam int HEX_LANES = 10;
   localparam int HEX_MAX_DIGITS = 8;

   // character codes
   localparam logic [7:0] CH_BSLASH  = 8'h5c;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SLASH   = 8'h2f;
   localparam logic [7:0] CH_LOWER_B = 8'h62;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_LOWER_N = 8'h6e;
   localparam logic [7:0] CH_LOWER_R = 8'h72;
   localparam logic [7:0] CH_LOWER_T = 8'h74;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_V = 8'h76;
   localparam logic [7:0] CH_LOWER_E = 8'h65;
   localparam logic [7:0] CH_LOWER_X = 8'h78;
   localparam logic [7:0] CH_LOWER_U = 8'h75;
   localparam logic [7:0] CH_UPPER_U = 8'h55;
   localparam logic [7:0] CH_UPPER_N = 8'h4e;
   localparam logic [7:0] CH_UPPER_L = 8'h4c;
   localparam logic [7:0] CH_UPPER_P = 8'h50;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_UNDER   = 8'h5f;

   // code points
   localparam logic [15:0] CP_NEL  = 16'h0085;
   localparam logic [15:0] CP_NBSP = 16'h00a0;
   localparam logic [15:0] CP_LS   = 16'h2028;
   localparam logic [15:0] CP_PS   = 16'h2029;
   localparam logic [15:0] SURR_HIGH_FIRST = 16'hd800;
   localparam logic [15:0] SURR_HIGH_LAST  = 16'hdbff;
   localparam logic [20:0] SURR_LOW_FIRST  = 21'h00dc00;
   localparam logic [20:0] PLANE1_BASE     = 21'h010000;
   localparam logic signed [31:0] FAIL_VALUE = -32'sd1;

   // escape modes
   typedef enum logic [1:0] {
      MODE_NONE   = 2'd0,
      MODE_SINGLE = 2'd1,
      MODE_YAML   = 2'd2,
      MODE_JSON   = 2'd3
   } escape_mode_type;

   // outcome class found by the front end
   typedef enum logic [1:0] {
      KIND_FAIL  = 2'd0,
      KIND_VALUE = 2'd1,
      KIND_HEX   = 2'd2
   } kind_type;

   // number of hex digits after the escape letter
   typedef enum logic [1:0] {
      HEX_2 = 2'd0,
      HEX_4 = 2'd1,
      HEX_8 = 2'd2
   } hex_len_type;

   // input word
   typedef struct packed {
      logic [63:0] window_low;
      logic [31:0] window_high;
      logic [3:0]  avail_len;
   } req_type;

   // result word
   typedef struct packed {
      logic signed [31:0] result_value;
      logic [3:0]         consumed_bytes;
   } rsp_type;

   // front end findings handed to the merge stage
   typedef struct packed {
      kind_type    kind;
      logic [3:0]  fail_used;
      logic [15:0] simple_value;
      hex_len_type hex_len;
      logic        pair_ok;
   } front_info_type;

   function automatic logic [3:0] hex_count(hex_len_type h);
      logic [3:0] n;
      unique case (h)
         HEX_2:   n = 4'd2;
         HEX_4:   n = 4'd4;
         HEX_8:   n = 4'd8;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

endpackage

FILE: design/yjed_hex_lane.sv
// one hex digit lane: classifies a single window byte
module yjed_hex_lane
   import yjed_pkg::*;
(
   input  logic [7:0] char_in,
   output logic [3:0] nibble,
   output logic       bad
);

   // digit ranges 0-9, a-f, A-F
   always_comb begin
      nibble = 4'd0;
      bad    = 1'b0;
      priority if (char_in >= 8'h30 && char_in <= 8'h39) begin
         nibble = char_in[3:0];
      end else if ((char_in >= 8'h61 && char_in <= 8'h66) ||
                   (char_in >= 8'h41 && char_in <= 8'h46)) begin
         nibble = 4'(char_in[2:0] + 3'd1) + 4'd8;
      end else begin
         bad = 1'b1;
      end
   end

endmodule

FILE: design/yjed_front.sv
// front end: length clamp, mode checks and simple escape lookup
module yjed_front
   import yjed_pkg::*;
(
   input  escape_mode_type mode,
   input  req_type         req,
   output front_info_type  info
);

   logic [11:0][7:0] win;
   logic [3:0]       len;
   logic [7:0]       b0;
   logic [7:0]       b1;
   logic             yaml;
   logic             simple_hit;
   logic [15:0]      simple_value;

   assign win  = {req.window_high, req.window_low};
   assign b0   = win[0];
   assign b1   = win[1];
   assign yaml = (mode == MODE_YAML);
   assign len  = (req.avail_len > WINDOW_BYTES) ? WINDOW_BYTES : req.avail_len;

   // single character escapes, yaml-only ones gated by mode
   always_comb begin
      simple_hit   = 1'b1;
      simple_value = 16'd0;
      unique case (b1)
         CH_LOWER_B: simple_value = 16'h0008;
         CH_LOWER_F: simple_value = 16'h000c;
         CH_LOWER_N: simple_value = 16'h000a;
         CH_LOWER_R: simple_value = 16'h000d;
         CH_LOWER_T: simple_value = 16'h0009;
         CH_DQUOTE:  simple_value = 16'h0022;
         CH_SLASH:   simple_value = 16'h002f;
         CH_BSLASH:  simple_value = 16'h005c;
         CH_ZERO: begin
            simple_value = 16'h0000;
            simple_hit   = yaml;
         end
         CH_LOWER_A: begin
            simple_value = 16'h0007;
            simple_hit   = yaml;
         end
         CH_TAB: begin
            simple_value = 16'h0009;
            simple_hit   = yaml;
         end
         CH_LOWER_V: begin
            simple_value = 16'h000b;
            simple_hit   = yaml;
         end
         CH_LOWER_E: begin
            simple_value = 16'h001b;
            simple_hit   = yaml;
         end
         CH_SPACE: begin
            simple_value = 16'h0020;
            simple_hit   = yaml;
         end
         CH_UPPER_N: begin
            simple_value = CP_NEL;
            simple_hit   = yaml;
         end
         CH_UNDER: begin
            simple_value = CP_NBSP;
            simple_hit   = yaml;
         end
         CH_UPPER_L: begin
            simple_value = CP_LS;
            simple_hit   = yaml;
         end
         CH_UPPER_P: begin
            simple_value = CP_PS;
            simple_hit   = yaml;
         end
         default: simple_hit = 1'b0;
      endcase
   end

   // classify the escape
   always_comb begin
      info.kind         = KIND_FAIL;
      info.fail_used    = 4'd0;
      info.simple_value = simple_value;
      info.hex_len      = HEX_4;
      info.pair_ok      = (len == WINDOW_BYTES) && (win[6] == CH_BSLASH) &&
                          (win[7] == CH_LOWER_U);
      priority if (mode == MODE_NONE || len < 4'd2) begin
         info.fail_used = 4'd0;
      end else if (mode == MODE_SINGLE) begin
         priority if (b0 != CH_SQUOTE) begin
            info.fail_used = 4'd1;
         end else if (b1 != CH_SQUOTE) begin
            info.fail_used = 4'd2;
         end else begin
            info.kind         = KIND_VALUE;
            info.simple_value = 16'(CH_SQUOTE);
         end
      end else if (b0 != CH_BSLASH) begin
         info.fail_used = 4'd1;
      end else if (simple_hit) begin
         info.kind = KIND_VALUE;
      end else if (yaml && b1 != CH_LOWER_X && b1 != CH_LOWER_U && b1 != CH_UPPER_U) begin
         info.fail_used = 4'd0;
      end else if (!yaml && b1 != CH_LOWER_U) begin
         info.fail_used = 4'd2;
      end else begin
         priority if (b1 == CH_LOWER_X) begin
            info.hex_len = HEX_2;
         end else if (b1 == CH_UPPER_U) begin
            info.hex_len = HEX_8;
         end else begin
            info.hex_len = HEX_4;
         end
         // digits cut off by the available length
         if (hex_count(info.hex_len) + 4'd2 > len) begin
            info.fail_used = 4'd2;
         end else begin
            info.kind = KIND_HEX;
         end
      end
   end

endmodule

FILE: design/yjed_merge.sv
// merge stage: combines lane digits into the code point and byte count
module yjed_merge
   import yjed_pkg::*;
(
   input  front_info_type                info,
   input  logic [HEX_LANES-1:0]          lane_bad,
   input  logic [HEX_LANES-1:0][3:0]     lane_nib,
   output rsp_type                       rsp
);

   logic [3:0]  n;
   logic        bad_found;
   logic [3:0]  bad_used;
   logic [31:0] hex_value;
   logic [15:0] hi;
   logic [15:0] lo;
   logic        is_high;
   logic        pair_bad;
   logic [20:0] joined;

   // first bad digit among the lanes in use, lowest lane wins
   always_comb begin
      n         = hex_count(info.hex_len);
      bad_found = 1'b0;
      bad_used  = 4'd0;
      for (int i = HEX_MAX_DIGITS - 1; i >= 0; i--) begin
         if (4'(i) < n && lane_bad[i]) begin
            bad_found = 1'b1;
            bad_used  = 4'(i + 3);
         end
      end
   end

   // digit assembly
   always_comb begin
      unique case (info.hex_len)
         HEX_2:   hex_value = {24'd0, lane_nib[0], lane_nib[1]};
         HEX_4:   hex_value = {16'd0, lane_nib[0], lane_nib[1], lane_nib[2], lane_nib[3]};
         HEX_8:   hex_value = {lane_nib[0], lane_nib[1], lane_nib[2], lane_nib[3],
                               lane_nib[4], lane_nib[5], lane_nib[6], lane_nib[7]};
         default: hex_value = 32'd0;
      endcase
   end

   // surrogate pair join, low half taken as is
   assign hi       = hex_value[15:0];
   assign lo       = {lane_nib[6], lane_nib[7], lane_nib[8], lane_nib[9]};
   assign is_high  = (info.hex_len == HEX_4) && (hi >= SURR_HIGH_FIRST) &&
                     (hi <= SURR_HIGH_LAST) && info.pair_ok;
   assign pair_bad = |lane_bad[HEX_LANES-1 -: 4];
   assign joined   = PLANE1_BASE + {1'b0, hi[9:0], 10'd0} + 21'(lo) - SURR_LOW_FIRST;

   // final selection
   always_comb begin
      rsp.result_value   = FAIL_VALUE;
      rsp.consumed_bytes = 4'd0;
      unique case (info.kind)
         KIND_VALUE: begin
            rsp.result_value   = $signed({16'd0, info.simple_value});
            rsp.consumed_bytes = 4'd2;
         end
         KIND_HEX: begin
            priority if (bad_found) begin
               rsp.consumed_bytes = bad_used;
            end else if (is_high) begin
               if (!pair_bad) begin
                  rsp.result_value   = $signed({11'd0, joined});
                  rsp.consumed_bytes = WINDOW_BYTES;
               end
            end else begin
               rsp.result_value   = $signed(hex_value);
               rsp.consumed_bytes = n + 4'd2;
            end
         end
         default: begin
            rsp.consumed_bytes = info.fail_used;
         end
      endcase
   end

endmodule

FILE: design/yaml_json_escape_decoder_core.sv
// Escape sequence decoder: one window a cycle, ten hex digit lanes and a merge stage.
// Each result is strobed by rsp_valid for one cycle. Throughput: one word every
// cycle; busy is high only in reset. The result path runs through the lane register
// and the output register.
// Reset (synchronous): clears the pipeline valids and sets the escape mode to YAML.
module yaml_json_escape_decoder_core
   import yjed_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_payload,
   output logic       rsp_valid,
   output rsp_type    rsp_payload,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_wdata
);

   logic [11:0][7:0]              win;
   logic [HEX_LANES-1:0]          lane_bad;
   logic [HEX_LANES-1:0][3:0]     lane_nib;
   front_info_type                front_info;
   rsp_type                       merged;
   escape_mode_type               mode_ff;
   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   front_info_type                s1_info_ff;
   logic [HEX_LANES-1:0]          s1_bad_ff;
   logic [HEX_LANES-1:0][3:0]     s1_nib_ff;
   logic                          rsp_valid_ff;
   rsp_type                       rsp_ff;

   assign busy        = reset;
   assign csr_ready   = 1'b1;
   assign s1_valid_in = start && !busy;
   assign win         = {req_payload.window_high, req_payload.window_low};

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_YAML;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= escape_mode_type'(csr_wdata);
      end
   end

   // hex digit lanes over bytes 2 to 11
   for (genvar k = 0; k < HEX_LANES; k++) begin : g_lane
      yjed_hex_lane u_lane (
         .char_in (win[k + 2]),
         .nibble  (lane_nib[k]),
         .bad     (lane_bad[k])
      );
   end

   yjed_front u_front (
      .mode (mode_ff),
      .req  (req_payload),
      .info (front_info)
   );

   // lane register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_info_ff <= front_info;
      s1_bad_ff  <= lane_bad;
      s1_nib_ff  <= lane_nib;
   end

   yjed_merge u_merge (
      .info     (s1_info_ff),
      .lane_bad (s1_bad_ff),
      .lane_nib (s1_nib_ff),
      .rsp      (merged)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= merged;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   // every result comes from an accepted word
   a_result_has_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without an accepted word");

   // nothing consumed means failure
   a_zero_used_fails: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.consumed_bytes == 4'd0) |->
         rsp_payload.result_value == FAIL_VALUE)
      else $error("zero bytes consumed on a success");

   // a joined surrogate pair never fails
   a_pair_succeeds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.consumed_bytes == WINDOW_BYTES) |->
         rsp_payload.result_value != FAIL_VALUE)
      else $error("full window consumed on a failure");
`endif

endmodule

FILE: bench/tb_yaml_json_escape_decoder_core.sv
// testbench for the escape sequence decoder core: directed and random words, scoreboard check
`timescale 1ns / 1ps

module tb_yaml_json_escape_decoder_core;
   import yjed_pkg::*;

   localparam int IDLE_LIMIT = 1000;
   localparam int PHASE_WORDS = 90;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_payload;
   logic       rsp_valid;
   rsp_type    rsp_payload;
   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_wdata;

   // expected results in the order their words were taken
   rsp_type         expected_escapes[$];
   escape_mode_type active_mode;
   int              error_count;
   int              calm_left;
   int              idle_cycles = 0;

   yaml_json_escape_decoder_core u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // hex digit value, 16 when the byte is not a hex digit
   function automatic logic [4:0] nibble_value(logic [7:0] c);
      if (c >= CH_ZERO && c <= "9") return {1'b0, c[3:0]};
      if (c >= "a" && c <= "f") return 5'd9 + {1'b0, c[3:0]};
      if (c >= "A" && c <= "F") return 5'd9 + {1'b0, c[3:0]};
      return 5'd16;
   endfunction

   // predicted code point and advance for one window in the given mode
   function automatic rsp_type decode_escape(escape_mode_type mode, req_type w);
      logic [95:0] win;
      logic [7:0]  c;
      logic [4:0]  d;
      logic [31:0] v;
      logic [31:0] hi;
      logic [3:0]  used;
      int          len;
      int          n;
      bit          hit;
      win = {w.window_high, w.window_low};
      len = (w.avail_len > WINDOW_BYTES) ? 12 : int'(w.avail_len);
      if (mode == MODE_NONE || len < 2) return {FAIL_VALUE, 4'd0};
      c = win[7:0];
      if (mode == MODE_SINGLE) begin
         if (c != CH_SQUOTE) return {FAIL_VALUE, 4'd1};
         if (win[15:8] != CH_SQUOTE) return {FAIL_VALUE, 4'd2};
         return {32'h27, 4'd2};
      end
      if (c != CH_BSLASH) return {FAIL_VALUE, 4'd1};
      c = win[15:8];

      // single letter escapes, the common set first
      hit = 1'b1;
      case (c)
         CH_LOWER_B: v = 32'h08;
         CH_LOWER_F: v = 32'h0c;
         CH_LOWER_N: v = 32'h0a;
         CH_LOWER_R: v = 32'h0d;
         CH_LOWER_T: v = 32'h09;
         CH_DQUOTE:  v = 32'h22;
         CH_SLASH:   v = 32'h2f;
         CH_BSLASH:  v = 32'h5c;
         default:    hit = 1'b0;
      endcase
      if (!hit && mode == MODE_YAML) begin
         hit = 1'b1;
         case (c)
            CH_ZERO:    v = 32'h00;
            CH_LOWER_A: v = 32'h07;
            CH_TAB:     v = 32'h09;
            CH_LOWER_V: v = 32'h0b;
            CH_LOWER_E: v = 32'h1b;
            CH_SPACE:   v = 32'h20;
            CH_UPPER_N: v = {16'h0, CP_NEL};
            CH_UNDER:   v = {16'h0, CP_NBSP};
            CH_UPPER_L: v = {16'h0, CP_LS};
            CH_UPPER_P: v = {16'h0, CP_PS};
            default:    hit = 1'b0;
         endcase
      end
      if (hit) return {v, 4'd2};

      // hex escapes
      n = 0;
      if (mode == MODE_YAML) begin
         if (c == CH_LOWER_X) n = 2;
         else if (c == CH_LOWER_U) n = 4;
         else if (c == CH_UPPER_U) n = 8;
         else return {FAIL_VALUE, 4'd0};
      end else if (c == CH_LOWER_U) begin
         n = 4;
      end
      if (n == 0 || n > len - 2) return {FAIL_VALUE, 4'd2};
      v = 32'h0;
      used = 4'd2;
      for (int i = 0; i < n; i++) begin
         d = nibble_value(win[8*(2+i) +: 8]);
         used = 4'(3 + i);
         if (d > 5'd15) return {FAIL_VALUE, used};
         v = {v[27:0], d[3:0]};
      end

      // high surrogate joined with a following \u value
      if (n == 4 && v >= 32'hd800 && v <= 32'hdbff && len >= 12 &&
          win[55:48] == CH_BSLASH && win[63:56] == CH_LOWER_U) begin
         hi = v;
         v = 32'h0;
         for (int i = 0; i < 4; i++) begin
            d = nibble_value(win[8*(8+i) +: 8]);
            if (d > 5'd15) return {FAIL_VALUE, 4'd0};
            v = {v[27:0], d[3:0]};
         end
         v = 32'h10000 + (hi - 32'hd800) * 32'h400 + v - 32'hdc00;
         used = 4'd12;
      end
      return {v, used};
   endfunction

   // mismatch line and count
   task automatic report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // one word into the block after a random gap
   task automatic send_word(req_type w);
      int gap;
      if (calm_left > 0) begin
         gap = 0;
         calm_left--;
      end else begin
         gap = $urandom_range(0, 14);
         if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_payload <= w;
      do @(posedge clock); while (busy);
      expected_escapes.push_back(decode_escape(active_mode, w));
   endtask

   // mode register write once the block has drained
   task automatic set_escape_mode(escape_mode_type m);
      start <= 1'b0;
      while (expected_escapes.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      active_mode = m;
   endtask

   // window from a text string, unused bytes zero
   function automatic req_type text_word(string s, int len);
      logic [95:0] win;
      req_type     w;
      win = '0;
      for (int i = 0; i < s.len() && i < 12; i++) win[8*i +: 8] = s[i];
      w.window_low = win[63:0];
      w.window_high = win[95:64];
      w.avail_len = 4'(len);
      return w;
   endfunction

   // hex digit character in random case
   function automatic logic [7:0] hex_char(logic [3:0] nib);
      if (nib < 4'd10) return CH_ZERO + nib;
      if ($urandom_range(0, 1) == 0) return "a" + nib - 4'd10;
      return "A" + nib - 4'd10;
   endfunction

   // random window: mostly well-formed escapes, some noise and broken ones
   function automatic req_type random_word(escape_mode_type mode);
      string       letters;
      logic [7:0]  b[12];
      logic [95:0] win;
      logic [15:0] half;
      logic [7:0]  letter;
      req_type     w;
      int          pick;
      int          sel;
      int          n;
      int          need;
      int          r;
      letters = "bfnrt\"/\\0a\tve N_LP";
      for (int i = 0; i < 12; i++) b[i] = 8'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
         w.window_low = {$urandom, $urandom};
         w.window_high = $urandom;
         w.avail_len = 4'($urandom);
         return w;
      end
      need = 2;
      if (mode == MODE_SINGLE) begin
         if (pick != 2) b[0] = CH_SQUOTE;
         if (pick != 3) b[1] = CH_SQUOTE;
      end else begin
         if (pick != 2) b[0] = CH_BSLASH;
         sel = $urandom_range(0, 5);
         if (sel < 2) begin
            b[1] = letters[$urandom_range(0, letters.len() - 1)];
         end else if (sel > 2) begin
            if (mode == MODE_YAML) begin
               r = $urandom_range(0, 2);
               letter = (r == 0) ? CH_LOWER_X : (r == 1) ? CH_LOWER_U : CH_UPPER_U;
            end else begin
               r = $urandom_range(0, 3);
               letter = (r == 0) ? CH_LOWER_X : (r == 1) ? CH_UPPER_U : CH_LOWER_U;
            end
            b[1] = letter;
            n = (letter == CH_LOWER_X) ? 2 : (letter == CH_LOWER_U) ? 4 : 8;
            for (int i = 0; i < n; i++) b[2+i] = hex_char(4'($urandom));
            if ($urandom_range(0, 7) == 0) b[2 + $urandom_range(0, n - 1)] = 8'($urandom);
            need = 2 + n;
            if (letter == CH_LOWER_U && $urandom_range(0, 2) == 0) begin
               half = 16'hd800 | 16'($urandom_range(0, 1023));
               for (int i = 0; i < 4; i++) b[2+i] = hex_char(half[4*(3-i) +: 4]);
               b[6] = CH_BSLASH;
               b[7] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : CH_LOWER_U;
               half = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                      16'hdc00 | 16'($urandom_range(0, 1023));
               for (int i = 0; i < 4; i++) b[8+i] = hex_char(half[4*(3-i) +: 4]);
               if ($urandom_range(0, 7) == 0) b[8 + $urandom_range(0, 3)] = 8'($urandom);
               need = 12;
            end
         end
      end
      r = $urandom_range(0, 7);
      if (r == 0) w.avail_len = 4'($urandom);
      else if (r == 1) w.avail_len = 4'(need - 1);
      else if (r < 5) w.avail_len = WINDOW_BYTES;
      else w.avail_len = 4'(need);
      for (int i = 0; i < 12; i++) win[8*i +: 8] = b[i];
      w.window_low = win[63:0];
      w.window_high = win[95:64];
      return w;
   endfunction

   // result check against the oldest expectation
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_escapes.size() == 0) begin
            report_mismatch($sformatf("result %0d/%0d with nothing expected",
                                      rsp_payload.result_value, rsp_payload.consumed_bytes));
         end else begin
            want = expected_escapes.pop_front();
            if (rsp_payload.result_value !== want.result_value)
               report_mismatch($sformatf("result_value %h, expected %h",
                                         rsp_payload.result_value, want.result_value));
            if (rsp_payload.consumed_bytes !== want.consumed_bytes)
               report_mismatch($sformatf("consumed_bytes %0d, expected %0d",
                                         rsp_payload.consumed_bytes, want.consumed_bytes));
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // mode none fails on anything, extremes of the window
   task automatic test_mode_none();
      set_escape_mode(MODE_NONE);
      send_word(text_word("\\n", 2));
      send_word('1);
   endtask

   // doubled quote and its broken forms
   task automatic test_single_quote();
      set_escape_mode(MODE_SINGLE);
      send_word(text_word("''", 2));
      send_word(text_word("'a", 12));
      send_word(text_word("a'", 2));
      send_word(text_word("''", 1));
   endtask

   // YAML escapes: simple, hex, surrogates and failures
   task automatic test_yaml_escapes();
      set_escape_mode(MODE_YAML);
      send_word(text_word("", 0));
      send_word('1);
      send_word(text_word("\\n", 2));
      send_word(text_word("\\L", 15));
      send_word(text_word("\\x41", 4));
      send_word(text_word("\\u00e9", 6));
      send_word(text_word("\\U0001F600", 10));
      send_word(text_word("\\UDEADBEEF", 10));
      send_word(text_word("\\q", 2));
      send_word(text_word("\\x4", 3));
      send_word(text_word("\\xG1", 4));
      send_word(text_word("\\ud83d\\ude00", 12));
      send_word(text_word("\\ud83d\\uZZ00", 12));
      send_word(text_word("\\ud83d\\ude00", 11));
   endtask

   // JSON escapes: a simple escape, \u, a surrogate pair and rejects
   task automatic test_json_escapes();
      set_escape_mode(MODE_JSON);
      send_word(text_word("\\/", 2));
      send_word(text_word("\\q", 2));
      send_word(text_word("\\x41", 4));
      send_word(text_word("\\u0041", 6));
      send_word(text_word("\\udbff\\udfff", 13));
      send_word(text_word("a\\", 2));
   endtask

   // random phases over all modes
   task automatic test_random_traffic();
      escape_mode_type plan[9];
      plan = '{MODE_NONE, MODE_SINGLE, MODE_YAML, MODE_JSON, MODE_SINGLE,
               MODE_JSON, MODE_YAML, MODE_NONE, MODE_JSON};
      foreach (plan[p]) begin
         set_escape_mode(plan[p]);
         repeat (PHASE_WORDS) send_word(random_word(active_mode));
      end
   endtask

   initial begin
      error_count = 0;
      calm_left = 0;
      active_mode = MODE_YAML;
      reset <= 1'b1;
      start <= 1'b0;
      req_payload <= '0;
      csr_valid <= 1'b0;
      csr_wdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_mode_none();
      test_single_quote();
      test_yaml_escapes();
      test_json_escapes();
      test_random_traffic();

      // drain and settle
      start <= 1'b0;
      while (expected_escapes.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      foreach (expected_escapes[k])
         report_mismatch($sformatf("expected result %0d never arrived", k));

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
